### rtl/core/hrl_pkg.sv
// Shared types, codes and defaults for the hash ring lookup block.
package hrl_pkg;

    // Fixed field widths.
    localparam int CFG_W  = 12;
    localparam int SLOT_W = 4;
    localparam int OP_W   = 2;
    localparam int HASH_W = 32;

    // Default sizes for the top level parameters.
    localparam int DEF_TABLE_DEPTH     = 2048;
    localparam int DEF_SLOTS_PER_ENTRY = 10;
    localparam int DEF_MAX_SERVERS     = 256;

    // Reset value of the point count register.
    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(1);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_POINT  = 2'd0,
        OP_WRITE_MEMBER = 2'd1,
        OP_LOOKUP       = 2'd2,
        OP_UNUSED       = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_MEMBER,
        ST_EMIT
    } t_state;

endpackage

### rtl/core/hrl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hash_ring_lookup.sv
// Top level of the consistent-hash ring lookup block.
//
// A command is taken at a rising edge where start is high and busy is low.
// Operation write point stores a point value. Operation write member does a
// read-modify-write of the entry's member row and holds busy high while the
// row is written back. A lookup runs a lower-bound binary search over the
// first table_count points (at most TABLE_DEPTH), one ring memory probe per
// cycle (about log2 of the count plus one, so 11 to 12 probes for 2048
// points), then reads the entry's member row and emits one result per cycle,
// in slot order. Busy stays high until the last result is emitted.
// The probe loop, memory read to compare to next address, sets the rate.
// Each result is on the o_ ports for one cycle with o_strobe high; the
// receiver cannot stall, so results are never held.
// The table_count register is written over its own valid/ready channel,
// which is always ready. After reset a clearing pass empties every member
// row, one row per cycle over all TABLE_DEPTH rows (2048 by default),
// during which busy is high; table_count resets to 1.
module hash_ring_lookup #(
    parameter int TABLE_DEPTH     = hrl_pkg::DEF_TABLE_DEPTH,
    parameter int SLOTS_PER_ENTRY = hrl_pkg::DEF_SLOTS_PER_ENTRY,
    parameter int MAX_SERVERS     = hrl_pkg::DEF_MAX_SERVERS,
    parameter int POS_W           = $clog2(TABLE_DEPTH),
    parameter int ID_W            = $clog2(MAX_SERVERS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Command channel.
    input  logic                       start,
    output logic                       busy,
    input  logic [hrl_pkg::OP_W-1:0]   i_operation,
    input  logic [POS_W-1:0]           i_position,
    input  logic [hrl_pkg::HASH_W-1:0] i_point_value,
    input  logic [hrl_pkg::SLOT_W-1:0] i_slot,
    input  logic [ID_W-1:0]            i_server_id,
    input  logic                       i_member_present,
    input  logic [hrl_pkg::HASH_W-1:0] i_hash_key,
    // Configuration channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hrl_pkg::CFG_W-1:0]  i_cfg_data,
    // Result channel.
    output logic                       o_strobe,
    output logic [POS_W-1:0]           o_entry_position,
    output logic [ID_W-1:0]            o_member_id,
    output logic                       o_has_member,
    output logic                       o_last
);

    import hrl_pkg::*;

    localparam int LW     = POS_W + 1;
    localparam int CW     = (CFG_W > LW) ? CFG_W : LW;
    localparam int SW     = ID_W + 1;
    localparam int ROW_W  = SLOTS_PER_ENTRY * SW;
    localparam int SIX_W  = (SLOTS_PER_ENTRY > 1) ? $clog2(SLOTS_PER_ENTRY) : 1;

    // Registers.
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_count, n_count;
    logic [HASH_W-1:0]   r_key, n_key;
    logic [LW-1:0]       r_lo, n_lo;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_n, n_n;
    logic [POS_W-1:0]    r_mid, n_mid;
    logic [POS_W-1:0]    r_entry, n_entry;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [ID_W-1:0]     r_id, n_id;
    logic                r_present, n_present;
    logic [POS_W-1:0]    r_clr, n_clr;
    logic                r_out_valid, n_out_valid;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    logic                r_out_has, n_out_has;
    logic                r_out_last, n_out_last;

    // Memory ports.
    logic                ring_we, ring_re;
    logic [POS_W-1:0]    ring_raddr;
    logic [HASH_W-1:0]   ring_rdata;
    logic                mem_we, mem_re;
    logic [POS_W-1:0]    mem_waddr, mem_raddr;
    logic [ROW_W-1:0]    mem_wdata, mem_rdata, row_mod;

    // Decoded command and search terms.
    logic                acc;
    t_op                 op;
    logic                pos_ok, slot_ok, member_ok;
    logic [LW-1:0]       n_eff;
    logic                lt;
    logic [LW-1:0]       s_lo, s_len, s_mid;
    logic [POS_W-1:0]    s_entry;

    // Member row fields and emit terms.
    logic [SLOTS_PER_ENTRY-1:0] row_v;
    logic [ID_W-1:0]     row_id [SLOTS_PER_ENTRY];
    logic [SLOT_W:0]     nxt;
    logic                cur_v, nxt_v, emit_last;

    assign acc       = start && (r_state == ST_IDLE);
    assign op        = t_op'(i_operation);
    assign pos_ok    = {1'b0, i_position} < LW'(TABLE_DEPTH);
    assign slot_ok   = {1'b0, i_slot} < (SLOT_W + 1)'(SLOTS_PER_ENTRY);
    assign member_ok = pos_ok && slot_ok;

    // Effective point count, clamped to the table depth.
    always_comb begin
        if (CW'(r_count) > CW'(TABLE_DEPTH)) begin
            n_eff = LW'(TABLE_DEPTH);
        end else begin
            n_eff = LW'(r_count);
        end
    end

    // One search step: compare the probed point, narrow the range, next probe.
    always_comb begin
        lt = ring_rdata < r_key;
        if (lt) begin
            s_lo  = LW'(r_mid) + LW'(1);
            s_len = r_len - (r_len >> 1) - LW'(1);
        end else begin
            s_lo  = r_lo;
            s_len = r_len >> 1;
        end
        s_mid = s_lo + (s_len >> 1);
        if (s_lo >= r_n) begin
            s_entry = '0;
        end else begin
            s_entry = s_lo[POS_W-1:0];
        end
    end

    // Unpack the member row and build the row for a slot update.
    always_comb begin
        row_mod = mem_rdata;
        for (int s = 0; s < SLOTS_PER_ENTRY; s++) begin
            row_v[s]  = mem_rdata[s*SW + ID_W];
            row_id[s] = mem_rdata[s*SW +: ID_W];
            if (r_slot == SLOT_W'(s)) begin
                row_mod[s*SW + ID_W] = r_present;
                if (r_present) begin
                    row_mod[s*SW +: ID_W] = r_id;
                end
            end
        end
    end

    // Emit terms for the current slot.
    always_comb begin
        nxt       = {1'b0, r_slot} + (SLOT_W + 1)'(1);
        cur_v     = row_v[r_slot[SIX_W-1:0]];
        nxt_v     = (nxt < (SLOT_W + 1)'(SLOTS_PER_ENTRY)) && row_v[nxt[SIX_W-1:0]];
        emit_last = !cur_v || !nxt_v;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == POS_W'(TABLE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    unique case (op)
                        OP_WRITE_MEMBER: begin
                            if (member_ok) begin
                                n_state = ST_MEMBER;
                            end
                        end
                        OP_LOOKUP: begin
                            if (n_eff == '0) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (s_len == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_MEMBER: begin
                n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result register values.
    always_comb begin
        n_count     = r_count;
        n_key       = r_key;
        n_lo        = r_lo;
        n_len       = r_len;
        n_n         = r_n;
        n_mid       = r_mid;
        n_entry     = r_entry;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_id        = r_id;
        n_present   = r_present;
        n_clr       = r_clr;
        n_out_valid = 1'b0;
        n_out_pos   = r_out_pos;
        n_out_id    = r_out_id;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;
        ring_we     = 1'b0;
        ring_re     = 1'b0;
        ring_raddr  = r_mid;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = row_mod;
        mem_re      = 1'b0;
        mem_raddr   = r_entry;

        if (i_cfg_valid) begin
            n_count = i_cfg_data;
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + POS_W'(1);
            end
            ST_IDLE: begin
                if (acc) begin
                    unique case (op)
                        OP_WRITE_POINT: begin
                            ring_we = pos_ok;
                        end
                        OP_WRITE_MEMBER: begin
                            n_pos     = i_position;
                            n_slot    = i_slot;
                            n_id      = i_server_id;
                            n_present = i_member_present;
                            mem_re    = member_ok;
                            mem_raddr = i_position;
                        end
                        OP_LOOKUP: begin
                            n_key   = i_hash_key;
                            n_n     = n_eff;
                            n_lo    = '0;
                            n_len   = n_eff;
                            n_mid   = POS_W'(n_eff >> 1);
                            n_slot  = '0;
                            n_entry = '0;
                            if (n_eff == '0) begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end else begin
                                ring_re    = 1'b1;
                                ring_raddr = POS_W'(n_eff >> 1);
                            end
                        end
                        default: begin
                            ring_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                n_lo  = s_lo;
                n_len = s_len;
                if (s_len == '0) begin
                    n_entry   = s_entry;
                    mem_re    = 1'b1;
                    mem_raddr = s_entry;
                end else begin
                    n_mid      = POS_W'(s_mid);
                    ring_re    = 1'b1;
                    ring_raddr = POS_W'(s_mid);
                end
            end
            ST_MEMBER: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = row_mod;
            end
            ST_EMIT: begin
                n_out_valid = 1'b1;
                n_out_pos   = r_entry;
                n_out_has   = cur_v;
                n_out_id    = cur_v ? row_id[r_slot[SIX_W-1:0]] : '0;
                n_out_last  = emit_last;
                n_slot      = nxt[SLOT_W-1:0];
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_count     <= COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_len      <= n_len;
        r_n        <= n_n;
        r_mid      <= n_mid;
        r_entry    <= n_entry;
        r_pos      <= n_pos;
        r_slot     <= n_slot;
        r_id       <= n_id;
        r_present  <= n_present;
        r_out_pos  <= n_out_pos;
        r_out_id   <= n_out_id;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    // Ring point memory.
    hrl_ram #(
        .WIDTH (HASH_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (POS_W)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (i_position),
        .i_wdata (i_point_value),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // Member rows: one valid bit and one server id per slot.
    hrl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (POS_W)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Outputs.
    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_strobe         = r_out_valid;
    assign o_entry_position = r_out_pos;
    assign o_member_id      = r_out_id;
    assign o_has_member     = r_out_has;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    // A result only follows a cycle of the emit state.
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_EMIT))
        else $error("result strobe without an emit cycle");

    // An entry without members gives a single, final result.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_has_member |-> o_last)
        else $error("empty entry result not marked last");

    // The search range is never empty while probing.
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_len != '0)
        else $error("search step with an empty range");

    // The last result of a lookup is not followed at once by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result directly after a last result");
`endif

endmodule
